### rtl/elevation_tint_colormap_unit_macros.svh
// Assertion macros for the elevation tint colormap unit.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef ELEVATION_TINT_COLORMAP_UNIT_MACROS_SVH
`define ELEVATION_TINT_COLORMAP_UNIT_MACROS_SVH

// checked only out of reset
`define ETCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ETCM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/etcm_pkg.sv
// Package for the elevation tint colormap unit: widths, band edges,
// reciprocal constants, item and queue status types. No dependencies.
`default_nettype none

package etcm_pkg;

    localparam int ELEV_W      = 16;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 24;
    localparam int NUM_CHAN    = 3;
    localparam int WEIGHT_W    = 12;
    localparam int NUM_W       = 20;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWLAND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPLAND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNTAIN = 2'd2;

    localparam logic signed [ELEV_W-1:0] ELEV_NODATA   = 16'sh8000;
    localparam logic signed [ELEV_W-1:0] ELEV_SEA      = 16'sd0;
    localparam logic signed [ELEV_W-1:0] EDGE_UPLAND   = 16'sd400;
    localparam logic signed [ELEV_W-1:0] EDGE_MOUNTAIN = 16'sd1500;
    localparam logic signed [ELEV_W-1:0] EDGE_TOP      = 16'sd5000;

    localparam longint SPAN_LOW  = 400;
    localparam longint SPAN_MID  = 1100;
    localparam longint SPAN_HIGH = 3500;

    // ceil(2^32 / span); exact floor division for any numerator below 2^20
    localparam longint RECIP_LOW  = ((64'sd1 <<< RECIP_SHIFT) + SPAN_LOW - 1) / SPAN_LOW;
    localparam longint RECIP_MID  = ((64'sd1 <<< RECIP_SHIFT) + SPAN_MID - 1) / SPAN_MID;
    localparam longint RECIP_HIGH = ((64'sd1 <<< RECIP_SHIFT) + SPAN_HIGH - 1) / SPAN_HIGH;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;

    typedef enum logic [2:0] {
        KIND_NODATA,
        KIND_WATER,
        KIND_LOW,
        KIND_MID,
        KIND_HIGH,
        KIND_TOP
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [WEIGHT_W-1:0]  w_lo;
        logic [WEIGHT_W-1:0]  w_hi;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

### rtl/etcm_front.sv
// Front end: takes elevation words, classifies them into bands and
// computes the two blend weights. Depends on etcm_pkg.
`default_nettype none

module etcm_front (
    input  wire logic                                 i_valid,
    input  wire logic signed [etcm_pkg::ELEV_W-1:0]   i_elevation,
    output logic                                      o_stall,
    input  wire etcm_pkg::t_q_status                  i_q_status,
    output logic                                      o_push,
    output etcm_pkg::t_item                           o_item
);
    import etcm_pkg::*;

    logic signed [ELEV_W:0] e_ext;
    logic signed [ELEV_W:0] w_lo_full;
    logic signed [ELEV_W:0] w_hi_full;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign e_ext   = {i_elevation[ELEV_W-1], i_elevation};

    always_comb begin
        w_lo_full   = '0;
        w_hi_full   = '0;
        o_item.kind = KIND_TOP;
        if (i_elevation == ELEV_NODATA) begin
            o_item.kind = KIND_NODATA;
        end else if (i_elevation <= ELEV_SEA) begin
            o_item.kind = KIND_WATER;
        end else if (i_elevation <= EDGE_UPLAND) begin
            o_item.kind = KIND_LOW;
            w_hi_full   = e_ext;
            w_lo_full   = {EDGE_UPLAND[ELEV_W-1], EDGE_UPLAND} - e_ext;
        end else if (i_elevation <= EDGE_MOUNTAIN) begin
            o_item.kind = KIND_MID;
            w_hi_full   = e_ext - {EDGE_UPLAND[ELEV_W-1], EDGE_UPLAND};
            w_lo_full   = {EDGE_MOUNTAIN[ELEV_W-1], EDGE_MOUNTAIN} - e_ext;
        end else if (i_elevation <= EDGE_TOP) begin
            o_item.kind = KIND_HIGH;
            w_hi_full   = e_ext - {EDGE_MOUNTAIN[ELEV_W-1], EDGE_MOUNTAIN};
            w_lo_full   = {EDGE_TOP[ELEV_W-1], EDGE_TOP} - e_ext;
        end
        o_item.w_lo = w_lo_full[WEIGHT_W-1:0];
        o_item.w_hi = w_hi_full[WEIGHT_W-1:0];
    end

endmodule

`default_nettype wire

### rtl/etcm_queue.sv
// Short word queue between the front end and the blend pipeline.
// Depends on etcm_pkg.
`default_nettype none

module etcm_queue #(
    parameter int DEPTH = etcm_pkg::QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire etcm_pkg::t_item       i_item,
    input  wire logic                  i_pop,
    output etcm_pkg::t_item            o_head,
    output etcm_pkg::t_q_status        o_status
);
    import etcm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CNT_W'(DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/etcm_back.sv
// Blend pipeline: weighted sum, reciprocal multiply, band select and
// output register. Depends on etcm_pkg.
`default_nettype none

module etcm_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire etcm_pkg::t_item                   i_head,
    input  wire etcm_pkg::t_q_status               i_q_status,
    output logic                                   o_pop,
    input  wire logic [etcm_pkg::COLOR_W-1:0]      i_lowland,
    input  wire logic [etcm_pkg::COLOR_W-1:0]      i_upland,
    input  wire logic [etcm_pkg::COLOR_W-1:0]      i_mountain,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [etcm_pkg::CHAN_W-1:0]            o_red,
    output logic [etcm_pkg::CHAN_W-1:0]            o_green,
    output logic [etcm_pkg::CHAN_W-1:0]            o_blue
);
    import etcm_pkg::*;

    logic                 en;
    logic [COLOR_W-1:0]   c_lo, c_hi;
    logic [RECIP_W-1:0]   recip;

    logic                 r_s1_valid;
    t_kind                r_s1_kind;
    logic [NUM_W-1:0]     r_s1_num  [NUM_CHAN];
    logic [NUM_W-1:0]     n_s1_num  [NUM_CHAN];

    logic                 r_s2_valid;
    t_kind                r_s2_kind;
    logic [PROD_W-1:0]    r_s2_prod [NUM_CHAN];
    logic [PROD_W-1:0]    n_s2_prod [NUM_CHAN];

    logic                 r_out_valid;
    logic [CHAN_W-1:0]    r_out_rgb [NUM_CHAN];
    logic [CHAN_W-1:0]    n_out_rgb [NUM_CHAN];

    assign en      = !r_out_valid || !i_stall;
    assign o_pop   = en && !i_q_status.empty;
    assign o_valid = r_out_valid;
    assign o_red   = r_out_rgb[0];
    assign o_green = r_out_rgb[1];
    assign o_blue  = r_out_rgb[2];

    // stage 1: pick band colors, weighted sum per channel
    always_comb begin
        unique case (i_head.kind)
            KIND_LOW: begin
                c_lo = i_lowland;
                c_hi = i_upland;
            end
            KIND_MID: begin
                c_lo = i_upland;
                c_hi = i_mountain;
            end
            KIND_HIGH: begin
                c_lo = i_mountain;
                c_hi = '0;
            end
            default: begin
                c_lo = '0;
                c_hi = '0;
            end
        endcase
        for (int k = 0; k < NUM_CHAN; k++) begin
            n_s1_num[k] =
                NUM_W'(i_head.w_lo) * NUM_W'(c_lo[COLOR_W - CHAN_W*(k+1) +: CHAN_W]) +
                NUM_W'(i_head.w_hi) * NUM_W'(c_hi[COLOR_W - CHAN_W*(k+1) +: CHAN_W]);
        end
    end

    // stage 2: divide by band span through its reciprocal
    always_comb begin
        unique case (r_s1_kind)
            KIND_LOW:  recip = RECIP_W'(RECIP_LOW);
            KIND_MID:  recip = RECIP_W'(RECIP_MID);
            KIND_HIGH: recip = RECIP_W'(RECIP_HIGH);
            default:   recip = '0;
        endcase
        for (int k = 0; k < NUM_CHAN; k++) begin
            n_s2_prod[k] = PROD_W'(r_s1_num[k]) * PROD_W'(recip);
        end
    end

    // stage 3: blended color in the blend bands, fixed colors outside them
    always_comb begin
        unique case (r_s2_kind) inside
            KIND_NODATA: begin
                n_out_rgb[0] = CHAN_MAX;
                n_out_rgb[1] = CHAN_MAX;
                n_out_rgb[2] = CHAN_MAX;
            end
            KIND_WATER: begin
                n_out_rgb[0] = CHAN_MIN;
                n_out_rgb[1] = CHAN_MIN;
                n_out_rgb[2] = CHAN_MAX;
            end
            KIND_LOW, KIND_MID, KIND_HIGH: begin
                for (int k = 0; k < NUM_CHAN; k++) begin
                    n_out_rgb[k] = r_s2_prod[k][RECIP_SHIFT +: CHAN_W];
                end
            end
            default: begin
                n_out_rgb[0] = CHAN_MIN;
                n_out_rgb[1] = CHAN_MIN;
                n_out_rgb[2] = CHAN_MIN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= !i_q_status.empty;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind <= i_head.kind;
            r_s2_kind <= r_s1_kind;
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_s1_num[k]  <= n_s1_num[k];
                r_s2_prod[k] <= n_s2_prod[k];
                r_out_rgb[k] <= n_out_rgb[k];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/elevation_tint_colormap_unit.sv
// Elevation tint colormap unit, top level: color registers, front end,
// queue and blend pipeline. Depends on etcm_pkg and the etcm_* modules.
//
// Input channel: i_valid / i_elevation, o_stall. A word is taken at a rising
// edge with i_valid high and o_stall low. Output channel: o_valid / o_red,
// o_green, o_blue, i_stall; a pixel is delivered at an edge with o_valid high
// and i_stall low, and holds steady while stalled.
// Color registers are written through i_cfg_we / i_cfg_index / i_cfg_data,
// index 0 lowland, 1 upland, 2 mountain, packed red in the top byte.
// A word passes the queue, then the stage 1, stage 2 and output registers.
// Throughput: one pixel per cycle while the receiver does not stall, set by
// the three-stage blend pipeline (weighted sum, reciprocal multiply, select).
// When the receiver stalls, the pipeline freezes and up to QUEUE_DEPTH words
// collect in the queue before o_stall rises.
// Reset (synchronous, active low) empties the queue and pipeline and clears
// the color registers to black.
`default_nettype none

module elevation_tint_colormap_unit #(
    parameter int QUEUE_DEPTH = etcm_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic signed [etcm_pkg::ELEV_W-1:0]   i_elevation,
    output logic                                      o_stall,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [etcm_pkg::CHAN_W-1:0]               o_red,
    output logic [etcm_pkg::CHAN_W-1:0]               o_green,
    output logic [etcm_pkg::CHAN_W-1:0]               o_blue,
    input  wire logic                                 i_cfg_we,
    input  wire logic [etcm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [etcm_pkg::COLOR_W-1:0]         i_cfg_data
);
    import etcm_pkg::*;

    logic [COLOR_W-1:0] r_lowland;
    logic [COLOR_W-1:0] r_upland;
    logic [COLOR_W-1:0] r_mountain;

    logic       push;
    logic       pop;
    t_item      front_item;
    t_item      head_item;
    t_q_status  q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowland  <= '0;
            r_upland   <= '0;
            r_mountain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWLAND:  r_lowland  <= i_cfg_data;
                CFG_UPLAND:   r_upland   <= i_cfg_data;
                CFG_MOUNTAIN: r_mountain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    etcm_front u_front (
        .i_valid     (i_valid),
        .i_elevation (i_elevation),
        .o_stall     (o_stall),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (front_item)
    );

    etcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    etcm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .i_lowland  (r_lowland),
        .i_upland   (r_upland),
        .i_mountain (r_mountain),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

endmodule

`default_nettype wire

### rtl/etcm_checker.sv
// Port-level checks for the elevation tint colormap unit, bound to the top.
// Depends on etcm_pkg and elevation_tint_colormap_unit_macros.svh.
`default_nettype none
`include "elevation_tint_colormap_unit_macros.svh"

module etcm_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_stall,
    input wire logic                                 o_valid,
    input wire logic                                 i_stall,
    input wire logic [etcm_pkg::CHAN_W-1:0]          o_red,
    input wire logic [etcm_pkg::CHAN_W-1:0]          o_green,
    input wire logic [etcm_pkg::CHAN_W-1:0]          o_blue
);

    `ETCM_ASSERT_RST(a_rst_out_empty, !i_rst_n |=> !o_valid, "output valid after reset")

    `ETCM_ASSERT_RST(a_rst_queue_empty, !i_rst_n |=> !o_stall, "input stalled after reset")

    `ETCM_ASSERT(a_stall_rise, $rose(o_stall) |-> $past(i_valid && !o_stall), "stall rose without a new word")

    `ETCM_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue), "stalled pixel changed")

endmodule

bind elevation_tint_colormap_unit etcm_checker u_etcm_checker (.*);

`default_nettype wire
